[rtl/utf8_decode_classify_defines.svh]
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Concurrent check wrappers shared by the decoder RTL; empty under SYNTH.
// ----------------------------------------------------------------------------
`ifndef UTF8_DECODE_CLASSIFY_DEFINES_SVH
`define UTF8_DECODE_CLASSIFY_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define U8DC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("utf8 decoder check failed");
// next-cycle implication, sampled on clk, off during reset
`define U8DC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("utf8 decoder check failed");
`else
`define U8DC_ASSERT_NOW(label, ante, cons)
`define U8DC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/utf8dc_pkg.sv]
// ----------------------------------------------------------------------------
// utf8dc_pkg
// Word types, constants and classification helpers for the UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8dc_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_t;

	typedef struct packed {
		logic [20:0] code_value;
		logic [2:0]  byte_count;
		logic        valid_res;
		logic        is_ideograph;
		logic        letter_flag;
		logic        is_digit;
		logic        ident_start;
		logic        ident_continue;
		logic        last_of_item;
	} char_t;

	localparam logic [20:0] CJK_A_LO   = 21'h004E00;
	localparam logic [20:0] CJK_A_HI   = 21'h009FFF;
	localparam logic [20:0] CJK_B_LO   = 21'h003400;
	localparam logic [20:0] CJK_B_HI   = 21'h004DBF;
	localparam logic [20:0] CJK_C_LO   = 21'h00F900;
	localparam logic [20:0] CJK_C_HI   = 21'h00FAFF;
	localparam logic [20:0] FW_DIG_LO  = 21'h00FF10;
	localparam logic [20:0] FW_DIG_HI  = 21'h00FF19;
	localparam logic [20:0] CODE_MAX   = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [1:0]  CONT_TAG   = 2'b10;

	localparam logic [2:0]  LEN_BAD    = 3'd0;
	localparam logic [2:0]  LEN_ONE    = 3'd1;
	localparam logic [2:0]  LEN_TWO    = 3'd2;
	localparam logic [2:0]  LEN_THREE  = 3'd3;
	localparam logic [2:0]  LEN_FOUR   = 3'd4;

	// sequence length from the lead byte, LEN_BAD for a byte that cannot lead
	function automatic logic [2:0] lead_len(logic [7:0] b);
		logic [2:0] len;
		priority if (b[7] == 1'b0)         len = LEN_ONE;
		else if (b[7:5] == 3'b110)         len = LEN_TWO;
		else if (b[7:4] == 4'b1110)        len = LEN_THREE;
		else if (b[7:3] == 5'b11110)       len = LEN_FOUR;
		else                               len = LEN_BAD;
		return len;
	endfunction

	function automatic char_t mk_invalid(logic [2:0] cnt);
		char_t r;
		r            = '0;
		r.byte_count = cnt;
		return r;
	endfunction

	function automatic char_t mk_valid(logic [20:0] cp, logic [2:0] cnt);
		char_t r;
		logic  ideo;
		logic  one;
		logic  alpha;
		logic  letter;
		logic  digit;
		logic  under;
		ideo   = (cp >= CJK_A_LO && cp <= CJK_A_HI) ||
		         (cp >= CJK_B_LO && cp <= CJK_B_HI) ||
		         (cp >= CJK_C_LO && cp <= CJK_C_HI);
		one    = (cnt == LEN_ONE);
		alpha  = one && ((cp >= 21'h61 && cp <= 21'h7A) || (cp >= 21'h41 && cp <= 21'h5A));
		letter = ideo || alpha;
		digit  = (one && cp >= 21'h30 && cp <= 21'h39) ||
		         (cp >= FW_DIG_LO && cp <= FW_DIG_HI);
		under  = one && (cp == 21'h5F);
		r.code_value     = cp;
		r.byte_count     = cnt;
		r.valid_res      = 1'b1;
		r.is_ideograph   = ideo;
		r.letter_flag    = letter;
		r.is_digit       = digit;
		r.ident_start    = under || letter;
		r.ident_continue = under || letter || digit;
		r.last_of_item   = 1'b0;
		return r;
	endfunction

	// completed multi-byte sequence: reject out-of-range values and surrogates
	function automatic char_t mk_finish(logic [20:0] cp, logic [2:0] cnt);
		char_t r;
		if (cp > CODE_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
			r = mk_invalid(cnt);
		end else begin
			r = mk_valid(cp, cnt);
		end
		return r;
	endfunction

endpackage

[rtl/utf8_decode_classify.sv]
// ----------------------------------------------------------------------------
// utf8_decode_classify
// Streaming UTF-8 decoder that tags each character with class flags.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle while text_stall is low and decodes it
// against the pending-sequence registers; results go into a four-word result
// queue that feeds the char port, so a byte is taken back to back while earlier
// results wait. A byte yields zero, one or two result words (two when a stray
// non-continuation byte cuts off a sequence and then decodes on its own).
// text_stall rises while the queue has room for fewer than two words, so
// sustained rate is one byte per clock as long as the char side drains one
// word per clock.
// ----------------------------------------------------------------------------
`include "utf8_decode_classify_defines.svh"

module utf8_decode_classify
	import utf8dc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  text_valid,
	output logic  text_stall,
	input  text_t text_item,
	output logic  char_valid,
	input  logic  char_stall,
	output char_t char_item
);

	// pending sequence
	logic [20:0] acc_q;
	logic [2:0]  exp_q;
	logic [2:0]  seen_q;

	// result queue
	char_t       fifo_q [4];
	logic [1:0]  wr_q;
	logic [1:0]  rd_q;
	logic [2:0]  cnt_q;

	logic        accept;
	logic        pop;
	logic [7:0]  b;
	logic        eot;

	// lead-byte decode
	logic [2:0]  st_len;
	logic        st_has;
	char_t       st_res;
	logic [20:0] st_acc;
	logic [2:0]  st_exp;
	logic [2:0]  st_seen;

	// item decode
	logic [20:0] acc_sh;
	logic [2:0]  seen_inc;
	char_t       r0;
	char_t       r1;
	logic [1:0]  nres;
	logic [20:0] acc_n;
	logic [2:0]  exp_n;
	logic [2:0]  seen_n;
	logic [1:0]  push;

	assign b          = text_item.text_byte;
	assign eot        = text_item.end_of_text;
	assign text_stall = (cnt_q > 3'd2);
	assign accept     = text_valid && !text_stall;
	assign char_valid = (cnt_q != 3'd0);
	assign char_item  = fifo_q[rd_q];
	assign pop        = char_valid && !char_stall;

	always_comb begin
		st_len  = lead_len(b);
		st_has  = 1'b0;
		st_res  = mk_invalid(LEN_ONE);
		st_acc  = '0;
		st_exp  = LEN_BAD;
		st_seen = 3'd0;
		if (st_len == LEN_BAD) begin
			st_has = 1'b1;
		end else if (st_len == LEN_ONE) begin
			st_has = 1'b1;
			st_res = mk_valid({13'd0, b}, LEN_ONE);
		end else if (eot) begin
			// lead byte on the last byte of text: truncated at once
			st_has = 1'b1;
		end else begin
			st_exp  = st_len;
			st_seen = 3'd1;
			if (st_len == LEN_TWO)        st_acc = {16'd0, b[4:0]};
			else if (st_len == LEN_THREE) st_acc = {17'd0, b[3:0]};
			else                          st_acc = {18'd0, b[2:0]};
		end
	end

	always_comb begin
		acc_sh   = {acc_q[14:0], b[5:0]};
		seen_inc = seen_q + 3'd1;
		r0       = st_res;
		r1       = st_res;
		nres     = 2'd0;
		acc_n    = acc_q;
		exp_n    = exp_q;
		seen_n   = seen_q;
		if (exp_q == LEN_BAD) begin
			nres   = {1'b0, st_has};
			acc_n  = st_acc;
			exp_n  = st_exp;
			seen_n = st_seen;
		end else if (b[7:6] == CONT_TAG) begin
			acc_n  = acc_sh;
			seen_n = seen_inc;
			if (seen_inc >= exp_q) begin
				r0     = mk_finish(acc_sh, exp_q);
				nres   = 2'd1;
				acc_n  = '0;
				exp_n  = LEN_BAD;
				seen_n = 3'd0;
			end else if (eot) begin
				r0     = mk_invalid(seen_inc);
				nres   = 2'd1;
				acc_n  = '0;
				exp_n  = LEN_BAD;
				seen_n = 3'd0;
			end
		end else begin
			// stray byte: close the partial sequence, then decode it as a lead
			r0     = mk_invalid(seen_q);
			r1     = st_res;
			nres   = st_has ? 2'd2 : 2'd1;
			acc_n  = st_acc;
			exp_n  = st_exp;
			seen_n = st_seen;
		end
		r0.last_of_item = (nres == 2'd1);
		r1.last_of_item = 1'b1;
		push = accept ? nres : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			exp_q  <= LEN_BAD;
			seen_q <= 3'd0;
			wr_q   <= '0;
			rd_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (accept) begin
				acc_q  <= acc_n;
				exp_q  <= exp_n;
				seen_q <= seen_n;
			end
			wr_q  <= wr_q + push;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, push} - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push != 2'd0) fifo_q[wr_q] <= r0;
		if (push == 2'd2) fifo_q[wr_q + 2'd1] <= r1;
	end

	`U8DC_ASSERT_NOW(a_pending_range, exp_q != LEN_BAD, seen_q != 3'd0 && seen_q < exp_q)
	`U8DC_ASSERT_NOW(a_invalid_clean, char_valid && !char_item.valid_res,
		char_item.code_value == 21'd0 && !char_item.letter_flag &&
		!char_item.is_digit && !char_item.ident_continue)
	`U8DC_ASSERT_NOW(a_count_range, char_valid, char_item.byte_count != 3'd0 && char_item.byte_count <= LEN_FOUR)
	`U8DC_ASSERT_NEXT(a_drain_only, pop && push == 2'd0, cnt_q == $past(cnt_q) - 3'd1)

endmodule
